// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// ===== hdl/hbts_pkg.sv =====
// ----------------------------------------------------------------------------
// hbts_pkg
// Types, constants and popcount helpers for the best-two Hamming selector.
// ----------------------------------------------------------------------------
package hbts_pkg;

   localparam int WORD_W      = 64;
   localparam int WORD_COUNT  = 4;
   localparam int DESC_BITS   = WORD_W * WORD_COUNT;
   localparam int DIST_W      = 9;   // holds 0..DESC_BITS
   localparam int CNT_W       = 7;   // holds 0..WORD_W
   localparam int CFG_W       = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HAMMING_DIST       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_HAMMING_DIFFERENCE = 2'd1;

   localparam logic [CFG_W-1:0] MAX_DIST_RESET = 9'd50;
   localparam logic [CFG_W-1:0] MIN_DIFF_RESET = 9'd0;

   localparam logic [31:0] MASK_1 = 32'h5555_5555;
   localparam logic [31:0] MASK_2 = 32'h3333_3333;
   localparam logic [31:0] MASK_4 = 32'h0F0F_0F0F;

   typedef logic [WORD_COUNT-1:0][WORD_W-1:0] desc_type;

   typedef struct packed {
      logic cand_valid;
      logic last;
   } item_ctl_type;

   typedef struct packed {
      logic [CFG_W-1:0] max_dist;
      logic [CFG_W-1:0] min_diff;
   } cfg_type;

   function automatic logic [5:0] count32(input logic [31:0] x);
      logic [31:0] v;
      logic [5:0]  b0, b1, b2, b3;
      v  = x - ((x >> 1) & MASK_1);
      v  = (v & MASK_2) + ((v >> 2) & MASK_2);
      v  = (v + (v >> 4)) & MASK_4;
      b0 = {2'b00, v[3:0]};
      b1 = {2'b00, v[11:8]};
      b2 = {2'b00, v[19:16]};
      b3 = {2'b00, v[27:24]};
      return b0 + b1 + b2 + b3;
   endfunction

   function automatic logic [CNT_W-1:0] count64(input logic [WORD_W-1:0] x);
      return {1'b0, count32(x[31:0])} + {1'b0, count32(x[63:32])};
   endfunction

endpackage

// ===== hdl/hbts_dist_pipe.sv =====
// ----------------------------------------------------------------------------
// hbts_dist_pipe
// Three-stage elastic pipeline: XOR register, per-word popcount register,
// distance register.
// ----------------------------------------------------------------------------
module hbts_dist_pipe #(
   parameter int INDEX_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  hbts_pkg::desc_type           in_query,
   input  hbts_pkg::desc_type           in_cand,
   input  logic [INDEX_BITS-1:0]        in_idx,
   input  hbts_pkg::item_ctl_type       in_ctl,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [hbts_pkg::DIST_W-1:0]  out_dist,
   output logic [INDEX_BITS-1:0]        out_idx,
   output hbts_pkg::item_ctl_type       out_ctl
);

   // stage x: XOR of query and candidate
   logic                         x_valid_ff, x_valid_in;
   hbts_pkg::desc_type           x_xor_ff;
   logic [INDEX_BITS-1:0]        x_idx_ff;
   hbts_pkg::item_ctl_type       x_ctl_ff;

   // stage c: per-word bit counts
   logic                                               c_valid_ff, c_valid_in;
   logic [hbts_pkg::WORD_COUNT-1:0][hbts_pkg::CNT_W-1:0] c_cnt_ff, c_cnt_in;
   logic [INDEX_BITS-1:0]                              c_idx_ff;
   hbts_pkg::item_ctl_type                             c_ctl_ff;

   // stage d: full distance
   logic                         d_valid_ff, d_valid_in;
   logic [hbts_pkg::DIST_W-1:0]  d_dist_ff, d_dist_in;
   logic [INDEX_BITS-1:0]        d_idx_ff;
   hbts_pkg::item_ctl_type       d_ctl_ff;

   logic d_load_ok, c_load_ok, x_load_ok;

   // a stage may load when it is empty or its content moves on this cycle
   assign d_load_ok = !d_valid_ff || out_ready;
   assign c_load_ok = !c_valid_ff || d_load_ok;
   assign x_load_ok = !x_valid_ff || c_load_ok;

   assign x_valid_in = x_load_ok ? in_valid   : x_valid_ff;
   assign c_valid_in = c_load_ok ? x_valid_ff : c_valid_ff;
   assign d_valid_in = d_load_ok ? c_valid_ff : d_valid_ff;

   assign in_stall = !x_load_ok;

   always_comb begin
      for (int w = 0; w < hbts_pkg::WORD_COUNT; w++) begin
         c_cnt_in[w] = hbts_pkg::count64(x_xor_ff[w]);
      end
   end

   always_comb begin
      logic [hbts_pkg::DIST_W-1:0] sum;
      sum = '0;
      for (int w = 0; w < hbts_pkg::WORD_COUNT; w++) begin
         sum = sum + hbts_pkg::DIST_W'(c_cnt_ff[w]);
      end
      d_dist_in = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_load_ok) begin
         x_xor_ff <= in_query ^ in_cand;
         x_idx_ff <= in_idx;
         x_ctl_ff <= in_ctl;
      end
      if (c_load_ok) begin
         c_cnt_ff <= c_cnt_in;
         c_idx_ff <= x_idx_ff;
         c_ctl_ff <= x_ctl_ff;
      end
      if (d_load_ok) begin
         d_dist_ff <= d_dist_in;
         d_idx_ff  <= c_idx_ff;
         d_ctl_ff  <= c_ctl_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_dist  = d_dist_ff;
   assign out_idx   = d_idx_ff;
   assign out_ctl   = d_ctl_ff;

endmodule

// ===== hdl/hbts_select.sv =====
// ----------------------------------------------------------------------------
// hbts_select
// Best and second-best tracking per query, distinctiveness test and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbts_select #(
   parameter int INDEX_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hbts_pkg::cfg_type            cfg,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  logic [hbts_pkg::DIST_W-1:0]  item_dist,
   input  logic [INDEX_BITS-1:0]        item_idx,
   input  hbts_pkg::item_ctl_type       item_ctl,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_match_found,
   output logic [INDEX_BITS-1:0]        rsp_best_index,
   output logic [hbts_pkg::DIST_W-1:0]  rsp_best_distance
);

   logic                         best_valid_ff, best_valid_in;
   logic [hbts_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [INDEX_BITS-1:0]        best_idx_ff, best_idx_in;
   logic                         second_valid_ff, second_valid_in;
   logic [hbts_pkg::DIST_W-1:0]  second_dist_ff, second_dist_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [INDEX_BITS-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [hbts_pkg::DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   logic                         take, keep, is_best, is_second, found;
   logic                         upd_best_valid, upd_second_valid;
   logic [hbts_pkg::DIST_W-1:0]  upd_best_dist, upd_second_dist;
   logic [INDEX_BITS-1:0]        upd_best_idx;

   // only a last transaction needs room in the result register
   assign item_ready = !item_ctl.last || !rsp_valid_ff || !rsp_stall;
   assign take       = item_valid && item_ready;

   assign keep      = item_ctl.cand_valid && (item_dist <= cfg.max_dist);
   assign is_best   = keep && (!best_valid_ff || (item_dist < best_dist_ff));
   assign is_second = keep && !is_best && (!second_valid_ff || (item_dist < second_dist_ff));

   always_comb begin
      upd_best_valid   = best_valid_ff;
      upd_best_dist    = best_dist_ff;
      upd_best_idx     = best_idx_ff;
      upd_second_valid = second_valid_ff;
      upd_second_dist  = second_dist_ff;
      if (is_best) begin
         upd_second_valid = best_valid_ff;
         upd_second_dist  = best_dist_ff;
         upd_best_valid   = 1'b1;
         upd_best_dist    = item_dist;
         upd_best_idx     = item_idx;
      end else if (is_second) begin
         upd_second_valid = 1'b1;
         upd_second_dist  = item_dist;
      end
   end

   // second best never lies below best, so the gap cannot wrap
   assign found = upd_best_valid &&
                  (!upd_second_valid || ((upd_second_dist - upd_best_dist) >= cfg.min_diff));

   always_comb begin
      best_valid_in   = best_valid_ff;
      best_dist_in    = best_dist_ff;
      best_idx_in     = best_idx_ff;
      second_valid_in = second_valid_ff;
      second_dist_in  = second_dist_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_found_in    = rsp_found_ff;
      rsp_idx_in      = rsp_idx_ff;
      rsp_dist_in     = rsp_dist_ff;
      if (take) begin
         if (item_ctl.last) begin
            best_valid_in   = 1'b0;
            best_dist_in    = '0;
            best_idx_in     = '0;
            second_valid_in = 1'b0;
            second_dist_in  = '0;
            rsp_valid_in    = 1'b1;
            rsp_found_in    = found;
            rsp_idx_in      = found ? upd_best_idx  : '0;
            rsp_dist_in     = found ? upd_best_dist : '0;
         end else begin
            best_valid_in   = upd_best_valid;
            best_dist_in    = upd_best_dist;
            best_idx_in     = upd_best_idx;
            second_valid_in = upd_second_valid;
            second_dist_in  = upd_second_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff   <= 1'b0;
         second_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         best_valid_ff   <= best_valid_in;
         second_valid_ff <= second_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff   <= best_dist_in;
      best_idx_ff    <= best_idx_in;
      second_dist_ff <= second_dist_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_found   = rsp_found_ff;
   assign rsp_best_index    = rsp_idx_ff;
   assign rsp_best_distance = rsp_dist_ff;

   `ASSERT_PROP(a_second_needs_best, clock, reset, second_valid_ff |-> best_valid_ff)
   `ASSERT_PROP(a_order_kept, clock, reset,
      (best_valid_ff && second_valid_ff) |-> (second_dist_ff >= best_dist_ff))
   `ASSERT_PROP(a_clear_after_last, clock, reset,
      (take && item_ctl.last) |=> (!best_valid_ff && !second_valid_ff && rsp_valid_ff))
   `ASSERT_NEVER(a_no_match_zero, clock, reset,
      rsp_valid_ff && !rsp_found_ff && ((rsp_idx_ff != '0) || (rsp_dist_ff != '0)))

endmodule

// ===== hdl/hamming_best_two_match_selector_top.sv =====
// ----------------------------------------------------------------------------
// hamming_best_two_match_selector_top
// Best-two Hamming match selector for 256-bit binary descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one candidate per transaction: query and candidate words,
//   candidate index, mask bit and last flag. All candidates of one query are
//   sent in order; the one with req_last_candidate set closes the query.
//   rsp_* carries one result per query, produced by the last transaction.
//   csr_* writes max_hamming_dist (index 0) and min_hamming_difference
//   (index 1); csr_ready is always high. Write only while the block is idle.
// Throughput and result path:
//   One candidate per cycle while req_stall is low. After its last transaction
//   is accepted, a query's result passes the XOR, per-word popcount and
//   distance registers, then the best-two update into the result register.
// Reset:
//   Synchronous; clears the pipeline, the best-two state and the result
//   register, and restores the register defaults (50 and 0).
// Stall:
//   A held result blocks only a following last transaction; other candidates
//   keep flowing until that one reaches the result stage.
// ----------------------------------------------------------------------------
module hamming_best_two_match_selector_top #(
   parameter int INDEX_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hbts_pkg::WORD_W-1:0]       req_query_word0,
   input  logic [hbts_pkg::WORD_W-1:0]       req_query_word1,
   input  logic [hbts_pkg::WORD_W-1:0]       req_query_word2,
   input  logic [hbts_pkg::WORD_W-1:0]       req_query_word3,
   input  logic [hbts_pkg::WORD_W-1:0]       req_cand_word0,
   input  logic [hbts_pkg::WORD_W-1:0]       req_cand_word1,
   input  logic [hbts_pkg::WORD_W-1:0]       req_cand_word2,
   input  logic [hbts_pkg::WORD_W-1:0]       req_cand_word3,
   input  logic [INDEX_BITS-1:0]             req_candidate_index,
   input  logic                              req_candidate_valid,
   input  logic                              req_last_candidate,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_match_found,
   output logic [INDEX_BITS-1:0]             rsp_best_index,
   output logic [hbts_pkg::DIST_W-1:0]       rsp_best_distance,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hbts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hbts_pkg::CFG_W-1:0]        csr_wdata
);

   hbts_pkg::cfg_type            cfg_ff, cfg_in;
   hbts_pkg::desc_type           query, cand;
   hbts_pkg::item_ctl_type       req_ctl, item_ctl;
   logic                         item_valid, item_ready;
   logic [hbts_pkg::DIST_W-1:0]  item_dist;
   logic [INDEX_BITS-1:0]        item_idx;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hbts_pkg::CSR_MAX_HAMMING_DIST: begin
               cfg_in.max_dist = csr_wdata;
            end
            hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE: begin
               cfg_in.min_diff = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_dist <= hbts_pkg::MAX_DIST_RESET;
         cfg_ff.min_diff <= hbts_pkg::MIN_DIFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign query = {req_query_word3, req_query_word2, req_query_word1, req_query_word0};
   assign cand  = {req_cand_word3, req_cand_word2, req_cand_word1, req_cand_word0};

   assign req_ctl.cand_valid = req_candidate_valid;
   assign req_ctl.last       = req_last_candidate;

   hbts_dist_pipe #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dist_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_query  (query),
      .in_cand   (cand),
      .in_idx    (req_candidate_index),
      .in_ctl    (req_ctl),
      .out_valid (item_valid),
      .out_ready (item_ready),
      .out_dist  (item_dist),
      .out_idx   (item_idx),
      .out_ctl   (item_ctl)
   );

   hbts_select #(
      .INDEX_BITS (INDEX_BITS)
   ) u_select (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .item_valid        (item_valid),
      .item_ready        (item_ready),
      .item_dist         (item_dist),
      .item_idx          (item_idx),
      .item_ctl          (item_ctl),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_found   (rsp_match_found),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance)
   );

endmodule

// ===== bench/hamming_best_two_match_selector_top_test.sv =====
// ----------------------------------------------------------------------------
// hamming_best_two_match_selector_top_test
// Self-checking bench for the best-two Hamming match selector.
// A directed table covers descriptor extremes, ties, masked and last-only
// candidates and register extremes; constrained-by-hand random queries follow,
// with both handshakes idling in bursts and one long result back-pressure
// stretch. Each result is matched field by field to a predictor or typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hamming_best_two_match_selector_top_test;

   localparam int IDX_W        = 16;
   localparam int TOTAL_ITEMS  = 1050;
   localparam int QUIET_ITEMS  = 150;
   localparam int HOLD_AT      = 350;
   localparam int HOLD_CYCLES  = 80;
   localparam int CFG_PERIOD   = 120;
   localparam int SETTLE_CYC   = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   // indexes with no register behind them; writes there are dropped
   localparam logic [hbts_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [hbts_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic                          found;
      logic [IDX_W-1:0]              idx;
      logic [hbts_pkg::DIST_W-1:0]   distance;
   } match_result_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                          kind;
      hbts_pkg::desc_type                    query;
      hbts_pkg::desc_type                    cand;
      logic [IDX_W-1:0]                      idx;
      logic                                  cand_valid;
      logic                                  last;
      logic [hbts_pkg::CSR_INDEX_W-1:0]      reg_index;
      logic [hbts_pkg::CFG_W-1:0]            reg_value;
      bit                                    typed;
      match_result_type                      want;
   } stim_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [hbts_pkg::WORD_W-1:0]         req_query_word0, req_query_word1;
   logic [hbts_pkg::WORD_W-1:0]         req_query_word2, req_query_word3;
   logic [hbts_pkg::WORD_W-1:0]         req_cand_word0, req_cand_word1;
   logic [hbts_pkg::WORD_W-1:0]         req_cand_word2, req_cand_word3;
   logic [IDX_W-1:0]                    req_candidate_index;
   logic                                req_candidate_valid;
   logic                                req_last_candidate;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_match_found;
   logic [IDX_W-1:0]                    rsp_best_index;
   logic [hbts_pkg::DIST_W-1:0]         rsp_best_distance;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [hbts_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [hbts_pkg::CFG_W-1:0]          csr_wdata;

   hamming_best_two_match_selector_top #(.INDEX_BITS(IDX_W)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_query_word0     (req_query_word0),
      .req_query_word1     (req_query_word1),
      .req_query_word2     (req_query_word2),
      .req_query_word3     (req_query_word3),
      .req_cand_word0      (req_cand_word0),
      .req_cand_word1      (req_cand_word1),
      .req_cand_word2      (req_cand_word2),
      .req_cand_word3      (req_cand_word3),
      .req_candidate_index (req_candidate_index),
      .req_candidate_valid (req_candidate_valid),
      .req_last_candidate  (req_last_candidate),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_match_found     (rsp_match_found),
      .rsp_best_index      (rsp_best_index),
      .rsp_best_distance   (rsp_best_distance),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state
   // ---------------------------------------------------------------------
   int unsigned   thr_max_dist;
   int unsigned   thr_min_gap;
   int unsigned   top_dist;
   bit            top_present;
   logic [IDX_W-1:0] top_idx;
   int unsigned   runner_dist;
   bit            runner_present;

   match_result_type expected_matches[$];
   stim_row_type     directed_rows[$];

   int  mismatches;
   int  cycle_count;
   int  items_sent;
   int  queries_closed;
   int  matches_accepted;
   int  csr_writes;
   bit  quiet;
   bit  hold_trigger;

   // ---------------------------------------------------------------------
   // Clock, reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_matches.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   task automatic clear_best_two();
      top_dist       = 0;
      top_present    = 1'b0;
      top_idx        = '0;
      runner_dist    = 0;
      runner_present = 1'b0;
   endtask

   task automatic predict_candidate(input hbts_pkg::desc_type q, input hbts_pkg::desc_type c,
                                    input logic [IDX_W-1:0] idx, input logic cand_valid,
                                    input logic last, output bit produced,
                                    output match_result_type res);
      int unsigned cand_dist;
      bit          found;
      cand_dist = $countones(q ^ c);
      produced  = 1'b0;
      res       = '0;
      if (cand_valid && cand_dist < thr_max_dist + 1) begin
         if (!top_present || cand_dist < top_dist) begin
            runner_dist    = top_dist;
            runner_present = top_present;
            top_dist       = cand_dist;
            top_idx        = idx;
            top_present    = 1'b1;
         end else if (!runner_present || cand_dist < runner_dist) begin
            runner_dist    = cand_dist;
            runner_present = 1'b1;
         end
      end
      if (last) begin
         found = top_present &&
                 (!runner_present || (runner_dist - top_dist) >= thr_min_gap);
         produced     = 1'b1;
         res.found    = found;
         res.idx      = found ? top_idx : '0;
         res.distance = found ? hbts_pkg::DIST_W'(top_dist) : '0;
         clear_best_two();
      end
   endtask

   function automatic void add_expected(input match_result_type m);
      expected_matches.insert(expected_matches.size(), m);
   endfunction

   function automatic void add_row(input stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string what, input match_result_type want,
                                input match_result_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("[%0t] %s: expected found=%0b idx=%0h dist=%0d, got found=%0b idx=%0h dist=%0d",
                  $realtime, what, want.found, want.idx, want.distance,
                  got.found, got.idx, got.distance);
   endtask

   always @(posedge clock) begin
      match_result_type got;
      match_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_match_found, rsp_best_index, rsp_best_distance};
         if (expected_matches.size() == 0) begin
            note_mismatch("result with nothing expected", '0, got);
         end else begin
            want = expected_matches.pop_front();
            if (got.found !== want.found || got.idx !== want.idx ||
                got.distance !== want.distance)
               note_mismatch("result mismatch", want, got);
            queries_closed++;
            if (got.found === 1'b1)
               matches_accepted++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, one long hold, none at the end
   // ---------------------------------------------------------------------
   initial begin
      int  stall_left;
      int  gap_left;
      int  hold_left;
      bit  hold_taken;
      logic next_stall;
      stall_left = 0;
      gap_left   = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            next_stall = 1'b1;
            hold_left--;
         end else if (quiet) begin
            next_stall = 1'b0;
         end else if (stall_left > 0) begin
            next_stall = 1'b1;
            stall_left--;
         end else if (gap_left > 0) begin
            next_stall = 1'b0;
            gap_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            next_stall = 1'b1;
         end else begin
            gap_left   = $urandom_range(0, 20);
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic hbts_pkg::desc_type low_ones(input int n);
      bit [hbts_pkg::DESC_BITS-1:0] v;
      v = '0;
      for (int i = 0; i < n; i++)
         v[i] = 1'b1;
      return v;
   endfunction

   function automatic hbts_pkg::desc_type random_desc();
      hbts_pkg::desc_type d;
      for (int w = 0; w < hbts_pkg::WORD_COUNT; w++)
         d[w] = {$urandom, $urandom};
      return d;
   endfunction

   // flip exactly k distinct bits of base
   function automatic hbts_pkg::desc_type flip_bits(input hbts_pkg::desc_type base,
                                                    input int k);
      bit [hbts_pkg::DESC_BITS-1:0] mask;
      int need;
      int cnt;
      int pos;
      mask = '0;
      cnt  = 0;
      need = (k > hbts_pkg::DESC_BITS / 2) ? hbts_pkg::DESC_BITS - k : k;
      while (cnt < need) begin
         pos = $urandom_range(0, hbts_pkg::DESC_BITS - 1);
         if (!mask[pos]) begin
            mask[pos] = 1'b1;
            cnt++;
         end
      end
      if (k > hbts_pkg::DESC_BITS / 2)
         mask = ~mask;
      return base ^ hbts_pkg::desc_type'(mask);
   endfunction

   function automatic stim_row_type item_row(input hbts_pkg::desc_type q,
                                             input hbts_pkg::desc_type c,
                                             input logic [IDX_W-1:0] idx,
                                             input logic cand_valid, input logic last);
      stim_row_type r;
      r            = '{kind: ROW_ITEM, default: '0};
      r.query      = q;
      r.cand       = c;
      r.idx        = idx;
      r.cand_valid = cand_valid;
      r.last       = last;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input hbts_pkg::desc_type q,
                                              input hbts_pkg::desc_type c,
                                              input logic [IDX_W-1:0] idx,
                                              input logic cand_valid,
                                              input logic found,
                                              input logic [IDX_W-1:0] best_idx,
                                              input logic [hbts_pkg::DIST_W-1:0] best_dist);
      stim_row_type r;
      r       = item_row(q, c, idx, cand_valid, 1'b1);
      r.typed = 1'b1;
      r.want  = '{found, best_idx, best_dist};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [hbts_pkg::CSR_INDEX_W-1:0] index,
                                            input logic [hbts_pkg::CFG_W-1:0] value);
      stim_row_type r;
      r           = '{kind: ROW_CSR, default: '0};
      r.reg_index = index;
      r.reg_value = value;
      return r;
   endfunction

   // one candidate transaction, with an optional idle burst ahead of it
   task automatic send_candidate(input hbts_pkg::desc_type q, input hbts_pkg::desc_type c,
                                 input logic [IDX_W-1:0] idx, input logic cand_valid,
                                 input logic last, input bit typed,
                                 input match_result_type typed_want);
      bit               produced;
      match_result_type predicted;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_query_word0     <= q[0];
      req_query_word1     <= q[1];
      req_query_word2     <= q[2];
      req_query_word3     <= q[3];
      req_cand_word0      <= c[0];
      req_cand_word1      <= c[1];
      req_cand_word2      <= c[2];
      req_cand_word3      <= c[3];
      req_candidate_index <= idx;
      req_candidate_valid <= cand_valid;
      req_last_candidate  <= last;
      req_valid           <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      predict_candidate(q, c, idx, cand_valid, last, produced, predicted);
      if (produced)
         add_expected(typed ? typed_want : predicted);
   endtask

   // wait until every result is back and the pipeline has emptied
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_register(input logic [hbts_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [hbts_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         hbts_pkg::CSR_MAX_HAMMING_DIST:       thr_max_dist = 32'(value);
         hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE: thr_min_gap  = 32'(value);
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_distance(input int prev_k);
      int r;
      int hi;
      r  = $urandom_range(0, 99);
      hi = (thr_max_dist + 8 > hbts_pkg::DESC_BITS) ? hbts_pkg::DESC_BITS : thr_max_dist + 8;
      if (r < 10 && prev_k >= 0)
         return prev_k;
      if (r < 55)
         return $urandom_range(0, hi);
      if (r < 75) begin
         r = int'(thr_max_dist) + $urandom_range(0, 4) - 2;
         return (r < 0) ? 0 : (r > hbts_pkg::DESC_BITS) ? hbts_pkg::DESC_BITS : r;
      end
      if (r < 90)
         return $urandom_range(0, hbts_pkg::DESC_BITS);
      return -1;  // unrelated candidate
   endfunction

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   task automatic build_directed();
      hbts_pkg::desc_type z;
      hbts_pkg::desc_type f;
      z = '0;
      f = '1;
      // extremes under reset thresholds (50, 0)
      add_row(typed_row(z, z, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 9'd0));
      add_row(typed_row(f, z, 16'h0000, 1'b1, 1'b0, 16'h0000, 9'd0));
      add_row(typed_row(f, f, 16'h1234, 1'b0, 1'b0, 16'h0000, 9'd0));
      // tie goes to second best
      add_row(item_row(z, low_ones(10), 16'd1, 1'b1, 1'b0));
      add_row(item_row(z, ~f ^ (f << 246), 16'd2, 1'b1, 1'b0));
      add_row(item_row(z, low_ones(50), 16'd3, 1'b1, 1'b1));
      // just over threshold, masked zero-distance candidate, exactly at threshold
      add_row(item_row(z, low_ones(51), 16'd5, 1'b1, 1'b0));
      add_row(item_row(z, z, 16'd6, 1'b0, 1'b0));
      add_row(item_row(z, low_ones(50), 16'd7, 1'b1, 1'b1));
      // best replaced, old best becomes second
      add_row(item_row(f, ~low_ones(30), 16'd8, 1'b1, 1'b0));
      add_row(item_row(f, ~low_ones(20), 16'd9, 1'b1, 1'b0));
      add_row(item_row(f, ~low_ones(25), 16'd10, 1'b1, 1'b1));
      // distinctiveness gap one short, then exactly met
      add_row(csr_row(hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE, 9'd5));
      add_row(item_row(z, low_ones(20), 16'd11, 1'b1, 1'b0));
      add_row(item_row(z, low_ones(24), 16'd12, 1'b1, 1'b1));
      add_row(item_row(z, low_ones(20), 16'd13, 1'b1, 1'b0));
      add_row(item_row(z, low_ones(25), 16'd14, 1'b1, 1'b1));
      // every distance kept
      add_row(csr_row(hbts_pkg::CSR_MAX_HAMMING_DIST, 9'd256));
      add_row(csr_row(hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE, 9'd0));
      add_row(typed_row(f, z, 16'hA5A5, 1'b1, 1'b1, 16'hA5A5, 9'd256));
      // only exact matches kept, largest gap required
      add_row(csr_row(hbts_pkg::CSR_MAX_HAMMING_DIST, 9'd0));
      add_row(csr_row(hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE, 9'd256));
      add_row(item_row(z, z, 16'h5A5A, 1'b1, 1'b0));
      add_row(typed_row(z, low_ones(1), 16'd3, 1'b1, 1'b1, 16'h5A5A, 9'd0));
      add_row(item_row(f, f, 16'd1, 1'b1, 1'b0));
      add_row(typed_row(z, z, 16'd2, 1'b1, 1'b0, 16'h0000, 9'd0));
      // writes to unused indexes change nothing
      add_row(csr_row(CSR_SPARE_2, 9'h1FF));
      add_row(csr_row(CSR_SPARE_3, 9'h1FF));
      add_row(item_row(z, z, 16'h0F0F, 1'b1, 1'b1));
      add_row(csr_row(hbts_pkg::CSR_MAX_HAMMING_DIST, 9'd50));
      add_row(csr_row(hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE, 9'd0));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      hbts_pkg::desc_type          query;
      hbts_pkg::desc_type          cand;
      int                          group_len;
      int                          k;
      int                          prev_k;
      int                          next_cfg_at;
      int                          phase;
      logic [hbts_pkg::CFG_W-1:0]  new_max;
      logic [hbts_pkg::CFG_W-1:0]  new_min;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_query_word0     = '0;
      req_query_word1     = '0;
      req_query_word2     = '0;
      req_query_word3     = '0;
      req_cand_word0      = '0;
      req_cand_word1      = '0;
      req_cand_word2      = '0;
      req_cand_word3      = '0;
      req_candidate_index = '0;
      req_candidate_valid = 1'b0;
      req_last_candidate  = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      mismatches          = 0;
      cycle_count         = 0;
      items_sent          = 0;
      queries_closed      = 0;
      matches_accepted    = 0;
      csr_writes          = 0;
      quiet               = 1'b0;
      hold_trigger        = 1'b0;
      thr_max_dist        = 32'(hbts_pkg::MAX_DIST_RESET);
      thr_min_gap         = 32'(hbts_pkg::MIN_DIFF_RESET);
      clear_best_two();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_directed();
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle_idle();
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_candidate(directed_rows[i].query, directed_rows[i].cand,
                           directed_rows[i].idx, directed_rows[i].cand_valid,
                           directed_rows[i].last, directed_rows[i].typed,
                           directed_rows[i].want);
         end
      end

      next_cfg_at = items_sent + CFG_PERIOD;
      phase       = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= next_cfg_at) begin
            settle_idle();
            case (phase % 5)
               0: begin new_max = 9'd256; new_min = 9'd0; end
               1: begin
                  new_max = 9'd0;
                  new_min = hbts_pkg::CFG_W'($urandom_range(0, 3));
               end
               2: begin
                  new_max = hbts_pkg::CFG_W'($urandom_range(30, 120));
                  new_min = hbts_pkg::CFG_W'($urandom_range(0, 8));
               end
               3: begin new_max = 9'd256; new_min = 9'd256; end
               default: begin
                  new_max = hbts_pkg::CFG_W'($urandom_range(0, 256));
                  new_min = hbts_pkg::CFG_W'($urandom_range(0, 256));
               end
            endcase
            write_register(hbts_pkg::CSR_MAX_HAMMING_DIST, new_max);
            write_register(hbts_pkg::CSR_MIN_HAMMING_DIFFERENCE, new_min);
            phase++;
            next_cfg_at = items_sent + CFG_PERIOD;
         end
         if (items_sent >= HOLD_AT)
            hold_trigger = 1'b1;
         if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;

         group_len = $urandom_range(1, 10);
         query     = random_desc();
         prev_k    = -1;
         for (int j = 0; j < group_len; j++) begin
            // occasionally the query itself changes inside a group
            if ($urandom_range(0, 19) == 0)
               query = random_desc();
            k    = pick_distance(prev_k);
            cand = (k < 0) ? random_desc() : flip_bits(query, k);
            if (k >= 0)
               prev_k = k;
            send_candidate(query, cand, IDX_W'($urandom), $urandom_range(0, 5) != 0,
                           j == group_len - 1, 1'b0, '0);
         end
      end

      settle_idle();
      $display("Sent %0d candidates over %0d queries with %0d register writes;",
               items_sent, queries_closed, csr_writes);
      $display("%0d matches accepted, %0d mismatches.", matches_accepted, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hbts_pkg.sv
hdl/hbts_dist_pipe.sv
hdl/hbts_select.sv
hdl/hamming_best_two_match_selector_top.sv
bench/hamming_best_two_match_selector_top_test.sv
